// File: hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and tables of the sphere point subdivider.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 2 * MAX_POINTS;
    localparam int PT_AW       = 10;          // point store address
    localparam int Q_AW        = 11;          // triangle queue address
    localparam int IDX_W       = 11;          // index / limit width
    localparam int COORD_W     = FRAC_BITS + 2;
    localparam int PT_W        = 3 * COORD_W;
    localparam int TRI_W       = 3 * PT_AW;
    localparam int SUM_W       = COORD_W + 1;
    localparam int MAG_W       = COORD_W;
    localparam int L2_W        = 38;
    localparam int NUM_W       = MAG_W + FRAC_BITS + 1;
    localparam int QUOT_W      = 18;
    localparam int REM_W       = 21;
    localparam int SQRT_STEPS  = L2_W / 2;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int SEED_COUNT  = 4;
    localparam int ONE_FIX     = 1 << FRAC_BITS;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRI_RD,
        ST_TRI_LATCH,
        ST_PT_RD,
        ST_PT_ACC,
        ST_SQ,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_PUSH,
        ST_EMIT
    } sps_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       tri_rd;
        logic       tri_latch;
        logic       pt_rd;
        logic       pt_acc;
        logic       sq;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic       push;
        logic       emit;
        logic [1:0] sel;
    } sps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic short_path;   // seed point or exhausted: no computation
    } sps_status_t;

    // Normalized tetrahedron vertices, {x, y, z}
    function automatic logic [PT_W-1:0] seed_point(input logic [1:0] n);
        logic [PT_W-1:0] p;
        unique case (n)
            2'd0: p = {18'sd0, 18'sd0, 18'sd65536};
            2'd1: p = {-18'sd30894, -18'sd53510, -18'sd21845};
            2'd2: p = {-18'sd30894, 18'sd53510, -18'sd21845};
            default: p = {18'sd61788, 18'sd0, -18'sd21845};
        endcase
        return p;
    endfunction

    // Initial triangle queue, {a, b, c}
    function automatic logic [TRI_W-1:0] seed_tri(input logic [1:0] n);
        logic [TRI_W-1:0] t;
        unique case (n)
            2'd0: t = {10'd1, 10'd2, 10'd3};
            2'd1: t = {10'd0, 10'd1, 10'd2};
            2'd2: t = {10'd0, 10'd1, 10'd3};
            default: t = {10'd0, 10'd2, 10'd3};
        endcase
        return t;
    endfunction

endpackage

// File: hdl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer: steps the datapath through fetch, sum, root, divide, push and emit.
// ----------------------------------------------------------------------------
module sps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sps_pkg::sps_status_t status,
    output sps_pkg::sps_cmd_t   cmd,
    output logic                busy
);
    import sps_pkg::*;

    sps_state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [4:0] step_reg, step_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sel    = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.short_path ? ST_EMIT : ST_TRI_RD;
                end
            end
            ST_TRI_RD:
            begin
                cmd.tri_rd = 1'b1;
                state_next = ST_TRI_LATCH;
            end
            ST_TRI_LATCH:
            begin
                cmd.tri_latch = 1'b1;
                k_next        = '0;
                state_next    = ST_PT_RD;
            end
            ST_PT_RD:
            begin
                // read corner k, add corner k-1 returned this cycle
                cmd.pt_rd  = 1'b1;
                cmd.pt_acc = (k_reg != 2'd0);
                if (k_reg == 2'd2)
                begin
                    state_next = ST_PT_ACC;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_PT_ACC:
            begin
                cmd.pt_acc = 1'b1;
                k_next     = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq = 1'b1;
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = ST_SQRT_INIT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_END;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DIV_END:
            begin
                cmd.div_end = 1'b1;
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = ST_PUSH;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTH
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("emit not followed by idle");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !busy)
        else $error("transaction accepted while busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> (step_reg < 5'(SQRT_STEPS)))
        else $error("root step counter out of range");
`endif

endmodule

// File: hdl/sps_datapath.sv
// ----------------------------------------------------------------------------
// sps_datapath
// Point store, triangle queue, corner sum, root unit and a divide unit shared by the axes.
// ----------------------------------------------------------------------------
module sps_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic                  point_limit_we,
    input  logic [10:0]           point_limit_data,
    input  sps_pkg::sps_cmd_t     cmd,
    output sps_pkg::sps_status_t  status,
    output logic                  point_valid,
    output logic [9:0]            point_index,
    output logic signed [17:0]    coord_x,
    output logic signed [17:0]    coord_y,
    output logic signed [17:0]    coord_z,
    output logic                  last_point,
    output logic                  exhausted
);
    import sps_pkg::*;

    // Sequence control registers
    logic [IDX_W-1:0] limit_reg, next_index_reg, idx_reg, tail_reg;
    logic             exh_reg;
    logic [IDX_W-1:0] idx_eff, limit_eff;
    logic             exh_now;

    // Work registers
    logic [PT_AW-1:0]          corner_reg [3];
    logic [PT_AW-1:0]          rd_corner_reg;
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic [L2_W-1:0]           l2_reg;
    logic [L2_W-1:0]           rad_reg, root_reg, bit_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [QUOT_W-1:0]         num_lo_reg;
    logic [QUOT_W-1:0]         quot_reg;
    logic signed [COORD_W-1:0] coord_reg [3];

    // Memory ports
    logic [TRI_W-1:0] tri_rdata, tri_wdata;
    logic [Q_AW-1:0]  tri_raddr;
    logic [PT_W-1:0]  pt_rdata, pt_wdata, pt_val;
    logic [PT_AW-1:0] pt_raddr;

    // Combinational helpers
    logic signed [SUM_W-1:0] sum_sel;
    logic [MAG_W-1:0]        mag_sel;
    logic [2*MAG_W-1:0]      sq_val;
    logic [L2_W-1:0]         trial;
    logic [NUM_W-1:0]        num_val;
    logic [REM_W-1:0]        rem_shift;
    logic [QUOT_W-1:0]       quot_cap;
    logic [TRI_W-1:0]        tri_val;

    assign idx_eff   = restart ? '0 : next_index_reg;
    assign limit_eff = (limit_reg > IDX_W'(MAX_POINTS)) ? IDX_W'(MAX_POINTS) : limit_reg;
    assign exh_now   = (idx_eff >= limit_eff);
    assign status.short_path = exh_now || (idx_eff < IDX_W'(SEED_COUNT));

    // Memories
    sps_ram #(.WIDTH(TRI_W), .DEPTH(QUEUE_DEPTH)) u_tri_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (tri_wdata),
        .raddr (tri_raddr),
        .rdata (tri_rdata)
    );

    sps_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk   (clk),
        .we    (cmd.push && (cmd.sel == 2'd0)),
        .waddr (idx_reg[PT_AW-1:0]),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // Queue head is the point index less the seeds
    assign tri_raddr = idx_reg - IDX_W'(SEED_COUNT);
    assign tri_val   = (idx_reg < IDX_W'(2 * SEED_COUNT)) ?
                       seed_tri(idx_reg[1:0]) : tri_rdata;

    // Corner select for reads
    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    pt_raddr = corner_reg[0];
            2'd1:    pt_raddr = corner_reg[1];
            default: pt_raddr = corner_reg[2];
        endcase
    end

    assign pt_val = (rd_corner_reg < PT_AW'(SEED_COUNT)) ?
                    seed_point(rd_corner_reg[1:0]) : pt_rdata;

    // Child triangle and new point
    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    tri_wdata = {corner_reg[0], corner_reg[1], idx_reg[PT_AW-1:0]};
            2'd1:    tri_wdata = {corner_reg[1], corner_reg[2], idx_reg[PT_AW-1:0]};
            default: tri_wdata = {corner_reg[2], corner_reg[0], idx_reg[PT_AW-1:0]};
        endcase
    end
    assign pt_wdata = {coord_reg[0], coord_reg[1], coord_reg[2]};

    // Axis select and magnitude
    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    sum_sel = sum_reg[0];
            2'd1:    sum_sel = sum_reg[1];
            default: sum_sel = sum_reg[2];
        endcase
    end
    assign mag_sel   = sum_sel[SUM_W-1] ? MAG_W'(-sum_sel) : MAG_W'(sum_sel);
    assign sq_val    = mag_sel * mag_sel;
    assign trial     = root_reg + bit_reg;
    assign num_val   = {1'b0, mag_sel, FRAC_BITS'(0)} + NUM_W'(root_reg >> 1);
    assign rem_shift = {rem_reg[REM_W-2:0], num_lo_reg[QUOT_W-1]};
    assign quot_cap  = (quot_reg > QUOT_W'(ONE_FIX)) ? QUOT_W'(ONE_FIX) : quot_reg;

    // Sequence registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= IDX_W'(MAX_POINTS);
            next_index_reg <= '0;
            tail_reg       <= Q_AW'(SEED_COUNT);
            point_valid    <= 1'b0;
        end
        else
        begin
            point_valid <= cmd.emit;
            if (point_limit_we)
            begin
                limit_reg <= point_limit_data;
            end
            if (cmd.accept && restart)
            begin
                next_index_reg <= '0;
                tail_reg       <= Q_AW'(SEED_COUNT);
            end
            if (cmd.push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (cmd.emit && !exh_reg)
            begin
                next_index_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= idx_eff;
            exh_reg <= exh_now;
        end
        if (cmd.tri_rd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
            l2_reg <= '0;
        end
        if (cmd.tri_latch)
        begin
            corner_reg[0] <= tri_val[3*PT_AW-1:2*PT_AW];
            corner_reg[1] <= tri_val[2*PT_AW-1:PT_AW];
            corner_reg[2] <= tri_val[PT_AW-1:0];
        end
        if (cmd.pt_rd)
        begin
            rd_corner_reg <= pt_raddr;
        end
        if (cmd.pt_acc)
        begin
            sum_reg[0] <= sum_reg[0] + SUM_W'($signed(pt_val[3*COORD_W-1:2*COORD_W]));
            sum_reg[1] <= sum_reg[1] + SUM_W'($signed(pt_val[2*COORD_W-1:COORD_W]));
            sum_reg[2] <= sum_reg[2] + SUM_W'($signed(pt_val[COORD_W-1:0]));
        end
        if (cmd.sq)
        begin
            l2_reg <= l2_reg + L2_W'(sq_val);
        end
        // bit-pair integer square root
        if (cmd.sqrt_init)
        begin
            rad_reg  <= l2_reg;
            root_reg <= '0;
            bit_reg  <= L2_W'(1) << (L2_W - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (rad_reg >= trial)
            begin
                rad_reg  <= rad_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        // restoring division, one quotient bit per cycle
        if (cmd.div_init)
        begin
            rem_reg    <= REM_W'(num_val[NUM_W-1:QUOT_W]);
            num_lo_reg <= num_val[QUOT_W-1:0];
            quot_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_shift >= REM_W'(root_reg))
            begin
                rem_reg  <= rem_shift - REM_W'(root_reg);
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
            num_lo_reg <= num_lo_reg << 1;
        end
        if (cmd.div_end)
        begin
            unique case (cmd.sel)
                2'd0:    coord_reg[0] <= sum_sel[SUM_W-1] ? -$signed(quot_cap) : $signed(quot_cap);
                2'd1:    coord_reg[1] <= sum_sel[SUM_W-1] ? -$signed(quot_cap) : $signed(quot_cap);
                default: coord_reg[2] <= sum_sel[SUM_W-1] ? -$signed(quot_cap) : $signed(quot_cap);
            endcase
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (exh_reg)
            begin
                point_index <= '0;
                coord_x     <= '0;
                coord_y     <= '0;
                coord_z     <= '0;
                last_point  <= 1'b0;
                exhausted   <= 1'b1;
            end
            else
            begin
                point_index <= idx_reg[PT_AW-1:0];
                if (idx_reg < IDX_W'(SEED_COUNT))
                begin
                    {coord_x, coord_y, coord_z} <= seed_point(idx_reg[1:0]);
                end
                else
                begin
                    coord_x <= coord_reg[0];
                    coord_y <= coord_reg[1];
                    coord_z <= coord_reg[2];
                end
                last_point <= ((idx_reg + 1'b1) == limit_eff);
                exhausted  <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> point_valid)
        else $error("emit without result strobe");
    a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> !(exhausted && last_point))
        else $error("exhausted result marked last");
    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && exhausted) |-> (coord_x == 0 && coord_y == 0 && coord_z == 0))
        else $error("exhausted result with nonzero coordinates");
`endif

endmodule

// File: hdl/sphere_point_subdivider.sv
// Seed points (0..3) and exhausted requests go from IDLE straight to EMIT, which registers
// the result and raises the strobe. Computed points pass through triangle fetch, corner sum,
// squares, 19 root steps and three divisions through one shift-subtract divide unit, then
// push the new point and its three child triangles, and emit.
// Flow: one transaction at a time; busy drops as the result is registered, and the next start
// is taken once the sequencer is back in IDLE.
// ----------------------------------------------------------------------------
// sphere_point_subdivider
// Top level: yields successive unit vectors of a subdivided tetrahedron.
// Reset: asynchronous, active low; limit returns to 1024, sequence to point 0.
// ----------------------------------------------------------------------------
module sphere_point_subdivider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               restart,
    output logic               busy,
    input  logic               point_limit_we,
    input  logic [10:0]        point_limit_data,
    output logic               point_valid,
    output logic [9:0]         point_index,
    output logic signed [17:0] coord_x,
    output logic signed [17:0] coord_y,
    output logic signed [17:0] coord_z,
    output logic               last_point,
    output logic               exhausted
);
    import sps_pkg::*;

    sps_cmd_t    cmd;
    sps_status_t status;

    // Sequencer
    sps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath
    sps_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .restart          (restart),
        .point_limit_we   (point_limit_we),
        .point_limit_data (point_limit_data),
        .cmd              (cmd),
        .status           (status),
        .point_valid      (point_valid),
        .point_index      (point_index),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .last_point       (last_point),
        .exhausted        (exhausted)
    );

endmodule
